// ----- hw/rtl/dsbf_pkg.sv -----
// Shared types and constants for the diagonal sharpen blend filter.
`default_nettype none

package dsbf_pkg;

  // Line store geometry: one memory per row slot, one entry per column
  localparam int unsigned MaxWidth = 1024;
  localparam int unsigned ColW     = 10;
  localparam int unsigned RowW     = 15;

  // Strength limit and reciprocal for floor(x * 64 / 25) as (x * Div25Recip) >> Div25Shift
  localparam logic [6:0]  StrengthMax = 7'd100;
  localparam logic [21:0] Div25Recip  = 22'd2684355;
  localparam int unsigned Div25Shift  = 20;

  // Register reset values
  localparam logic [10:0] WidthReset    = 11'd64;
  localparam logic [14:0] HeightReset   = 15'd64;
  localparam logic [6:0]  StrengthReset = 7'd50;

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    CfgImageWidth  = 2'd0,
    CfgImageHeight = 2'd1,
    CfgStrength    = 2'd2
  } cfg_reg_e;

  // Packed RGB pixel, red in the top byte
  typedef logic [23:0] rgb_t;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0]      red_out;
    logic [7:0]      green_out;
    logic [7:0]      blue_out;
    logic [ColW-1:0] out_col;
    logic [RowW-1:0] out_row;
    logic            last_of_item;
  } pix_out_t;

endpackage

`default_nettype wire

// ----- hw/rtl/diagonal_sharpen_blend_filter_unit.sv -----
// Top level of the diagonal sharpen blend filter: line store, pipeline and result emitter.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_ready_o  in_data_i   (pix_in_t)
//   out      output     out_valid_o/out_ready_i out_data_o (pix_out_t)
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One pixel enters per cycle while the pipeline advances; its first result passes the
// stage 1 and stage 2 registers and the emitter before it reaches the output.
// A pixel with two or three results holds the pipeline at the emitter until its
// last beat is taken, since the output port moves one beat per cycle.
// After reset a clearing pass zeroes both row memories, one entry of each per cycle;
// in_ready_o stays low until it ends. Configuration writes are taken at any time.
// A stalled output stops the whole pipeline.
`default_nettype none

module diagonal_sharpen_blend_filter_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire dsbf_pkg::pix_in_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output dsbf_pkg::pix_out_t     out_data_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [14:0]       cfg_data_i
);

  localparam int unsigned ColW = dsbf_pkg::ColW;
  localparam int unsigned RowW = dsbf_pkg::RowW;

  typedef struct packed {
    dsbf_pkg::rgb_t  pix;
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
    logic [6:0]      s;
    logic            parity;
    logic            emit_a;
    logic            filt;
    logic            emit_b;
    logic            emit_c;
  } s1_t;

  typedef struct packed {
    dsbf_pkg::rgb_t  pix;
    dsbf_pkg::rgb_t  centre;
    dsbf_pkg::rgb_t  upper;
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
    logic            emit_a;
    logic            filt;
    logic            emit_b;
    logic            emit_c;
  } s2_t;

  typedef struct packed {
    dsbf_pkg::rgb_t  px;
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
  } res_t;

  // Configuration registers
  logic [10:0] width_q;
  logic [14:0] height_q;
  logic [6:0]  strength_q;

  // Position counters and clearing pass
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic            clr_busy_q, clr_busy_d;
  logic [ColW-1:0] clr_addr_q, clr_addr_d;

  // Pipeline
  logic           s1_valid_q, s2_valid_q;
  s1_t            s1_q, s1_d;
  s2_t            s2_q, s2_d;
  dsbf_pkg::rgb_t evict_a_q, evict_b_q;
  dsbf_pkg::rgb_t evict_px, centre_px, upper_px, blend_px;

  // Emitter
  logic       em_valid_q, em_valid_d;
  logic [1:0] em_idx_q, em_idx_d, em_last_q, em_last_d;
  res_t       em_res_q [3];
  res_t       em_res_d [3];
  res_t       res_a, res_b, res_c, res_out;
  logic [1:0] res_cnt;
  logic       em_load;

  logic            adv, accept;
  logic [ColW-1:0] wm1, col_c;
  logic [RowW-1:0] hm1, row_c;
  logic [6:0]      str_c;

  dsbf_pkg::rgb_t  rd_a [2];
  dsbf_pkg::rgb_t  rd_b [2];

  // Configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= dsbf_pkg::WidthReset;
      height_q   <= dsbf_pkg::HeightReset;
      strength_q <= dsbf_pkg::StrengthReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dsbf_pkg::CfgImageWidth:  width_q    <= cfg_data_i[10:0];
        dsbf_pkg::CfgImageHeight: height_q   <= cfg_data_i;
        dsbf_pkg::CfgStrength:    strength_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Limit sizes and strength to their working ranges
  always_comb begin
    if (width_q == 11'd0) begin
      wm1 = '0;
    end else if (width_q > 11'(dsbf_pkg::MaxWidth)) begin
      wm1 = ColW'(dsbf_pkg::MaxWidth - 1);
    end else begin
      wm1 = ColW'(width_q - 11'd1);
    end
    hm1   = (height_q == '0) ? '0 : height_q - RowW'(1);
    str_c = (strength_q > dsbf_pkg::StrengthMax) ? dsbf_pkg::StrengthMax : strength_q;
    col_c = (col_q > wm1) ? wm1 : col_q;
    row_c = (row_q > hm1) ? hm1 : row_q;
  end

  // Handshake: the pipeline moves as one whenever the emitter frees up
  assign adv        = !em_valid_q || (out_ready_i && (em_idx_q == em_last_q));
  assign in_ready_o = adv && !clr_busy_q;
  assign accept     = in_valid_i && in_ready_o;

  // Advance position counters
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_c >= wm1) begin
        col_d = '0;
        row_d = (row_c >= hm1) ? '0 : row_c + RowW'(1);
      end else begin
        col_d = col_c + ColW'(1);
        row_d = row_c;
      end
    end
  end

  // Sweep both row memories to zero after reset
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + ColW'(1);
      if (clr_addr_q == ColW'(dsbf_pkg::MaxWidth - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // Row memories: slot k holds rows of parity k; write current, read both
  for (genvar k = 0; k < 2; k++) begin : g_slot
    logic            is_cur, we;
    logic [ColW-1:0] waddr, raddr_a;
    dsbf_pkg::rgb_t  wdata;

    assign is_cur  = (row_c[0] == 1'(k));
    assign we      = clr_busy_q || (accept && is_cur);
    assign waddr   = clr_busy_q ? clr_addr_q : col_c;
    assign wdata   = clr_busy_q ? '0 : dsbf_pkg::rgb_t'(in_data_i);
    assign raddr_a = is_cur ? col_c : col_c - ColW'(1);

    dsbf_ram #(
      .Width($bits(dsbf_pkg::rgb_t)),
      .Depth(dsbf_pkg::MaxWidth)
    ) u_ram (
      .clk_i     (clk_i),
      .we_i      (we),
      .waddr_i   (waddr),
      .wdata_i   (wdata),
      .re_i      (accept),
      .raddr_a_i (raddr_a),
      .raddr_b_i (wm1),
      .rdata_a_o (rd_a[k]),
      .rdata_b_o (rd_b[k])
    );
  end

  // Stage 1 capture: pixel, position and result flags
  always_comb begin
    s1_d.pix    = dsbf_pkg::rgb_t'(in_data_i);
    s1_d.col    = col_c;
    s1_d.row    = row_c;
    s1_d.s      = str_c;
    s1_d.parity = row_c[0];
    s1_d.emit_a = (row_c != '0) && (col_c != '0);
    s1_d.filt   = (row_c > RowW'(1)) && (col_c > ColW'(1));
    s1_d.emit_b = (row_c != '0) && (col_c == wm1);
    s1_d.emit_c = (row_c == hm1);
  end

  // Pick memory outputs by row parity
  assign evict_px  = s1_q.parity ? rd_a[1] : rd_a[0];
  assign centre_px = s1_q.parity ? rd_a[0] : rd_a[1];
  assign upper_px  = s1_q.parity ? rd_b[0] : rd_b[1];

  dsbf_blend u_blend (
    .clk_i (clk_i),
    .en_i  (adv),
    .ul_i  (evict_b_q),
    .m_i   (centre_px),
    .lr_i  (s1_q.pix),
    .s_i   (s1_q.s),
    .px_o  (blend_px)
  );

  always_comb begin
    s2_d.pix    = s1_q.pix;
    s2_d.centre = centre_px;
    s2_d.upper  = upper_px;
    s2_d.col    = s1_q.col;
    s2_d.row    = s1_q.row;
    s2_d.emit_a = s1_q.emit_a;
    s2_d.filt   = s1_q.filt;
    s2_d.emit_b = s1_q.emit_b;
    s2_d.emit_c = s1_q.emit_c;
  end

  // Hold pipeline payload while stalled
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
    end
  end

  // Shift evicted pixels per item; the older one is the upper-left neighbour
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      evict_a_q  <= '0;
      evict_b_q  <= '0;
    end else if (adv) begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        evict_b_q <= evict_a_q;
        evict_a_q <= evict_px;
      end
    end
  end

  // Build up to three results and pack them in order
  always_comb begin
    res_a.px  = s2_q.filt ? blend_px : s2_q.centre;
    res_a.col = s2_q.col - ColW'(1);
    res_a.row = s2_q.row - RowW'(1);
    res_b.px  = s2_q.upper;
    res_b.col = s2_q.col;
    res_b.row = s2_q.row - RowW'(1);
    res_c.px  = s2_q.pix;
    res_c.col = s2_q.col;
    res_c.row = s2_q.row;
    res_cnt   = 2'(s2_q.emit_a) + 2'(s2_q.emit_b) + 2'(s2_q.emit_c);
    em_load   = adv && s2_valid_q && (res_cnt != 2'd0);
  end

  // Emitter: load on advance, step one beat per output handshake
  always_comb begin
    em_valid_d  = em_valid_q;
    em_idx_d    = em_idx_q;
    em_last_d   = em_last_q;
    em_res_d[0] = em_res_q[0];
    em_res_d[1] = em_res_q[1];
    em_res_d[2] = em_res_q[2];
    if (adv) begin
      em_valid_d = em_load;
      em_idx_d   = 2'd0;
      if (em_load) begin
        em_last_d   = res_cnt - 2'd1;
        em_res_d[0] = s2_q.emit_a ? res_a : (s2_q.emit_b ? res_b : res_c);
        em_res_d[1] = s2_q.emit_a ? (s2_q.emit_b ? res_b : res_c) : res_c;
        em_res_d[2] = res_c;
      end
    end else if (out_ready_i) begin
      em_idx_d = em_idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_valid_q <= 1'b0;
      em_idx_q   <= 2'd0;
      em_last_q  <= 2'd0;
    end else begin
      em_valid_q <= em_valid_d;
      em_idx_q   <= em_idx_d;
      em_last_q  <= em_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    em_res_q[0] <= em_res_d[0];
    em_res_q[1] <= em_res_d[1];
    em_res_q[2] <= em_res_d[2];
  end

  // Drive the output beat
  always_comb begin
    case (em_idx_q)
      2'd0:    res_out = em_res_q[0];
      2'd1:    res_out = em_res_q[1];
      default: res_out = em_res_q[2];
    endcase
  end

  assign out_valid_o             = em_valid_q;
  assign out_data_o.red_out      = res_out.px[23:16];
  assign out_data_o.green_out    = res_out.px[15:8];
  assign out_data_o.blue_out     = res_out.px[7:0];
  assign out_data_o.out_col      = res_out.col;
  assign out_data_o.out_row      = res_out.row;
  assign out_data_o.last_of_item = (em_idx_q == em_last_q);

endmodule

`default_nettype wire

// ----- hw/rtl/dsbf_ram.sv -----
// Generic single-write, dual-read synchronous RAM with registered read data.
`default_nettype none

module dsbf_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_a_i,
  input  wire logic [AddrW-1:0] raddr_b_i,
  output logic      [Width-1:0] rdata_a_o,
  output logic      [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write, and read old data on a same-address collision
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/dsbf_blend.sv -----
// Per-channel sharpen, clamp and strength blend, with a register between the multiplies.
`default_nettype none

module dsbf_blend (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire dsbf_pkg::rgb_t ul_i,
  input  wire dsbf_pkg::rgb_t m_i,
  input  wire dsbf_pkg::rgb_t lr_i,
  input  wire logic [6:0]     s_i,
  output dsbf_pkg::rgb_t      px_o
);

  logic [6:0] s_inv;

  assign s_inv = dsbf_pkg::StrengthMax - s_i;

  for (genvar k = 0; k < 3; k++) begin : g_chan
    logic        [7:0]  ul, m, lr, vc;
    logic        [9:0]  m3;
    logic signed [10:0] v;
    logic        [14:0] x1_d, x1_q, x2_d, x2_q;
    logic        [36:0] p1, p2;
    logic        [15:0] q1, q2, sum;

    assign ul = ul_i[8*k +: 8];
    assign m  = m_i[8*k +: 8];
    assign lr = lr_i[8*k +: 8];

    // Sharpen: three times the centre less the two diagonal neighbours, clamped
    assign m3 = {2'b00, m} + {1'b0, m, 1'b0};
    assign v  = $signed({1'b0, m3}) - $signed({3'b000, ul}) - $signed({3'b000, lr});

    always_comb begin
      if (v < 0) begin
        vc = 8'd0;
      end else if (v > 11'sd255) begin
        vc = 8'd255;
      end else begin
        vc = v[7:0];
      end
    end

    // Weight by strength and by its complement
    assign x1_d = 15'(vc) * 15'(s_i);
    assign x2_d = 15'(m) * 15'(s_inv);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x1_q <= x1_d;
        x2_q <= x2_d;
      end
    end

    // Scale by 256/100 with floor, then sum and drop the fraction
    assign p1  = 37'(x1_q) * 37'(dsbf_pkg::Div25Recip);
    assign p2  = 37'(x2_q) * 37'(dsbf_pkg::Div25Recip);
    assign q1  = p1[dsbf_pkg::Div25Shift +: 16];
    assign q2  = p2[dsbf_pkg::Div25Shift +: 16];
    assign sum = q1 + q2;

    assign px_o[8*k +: 8] = sum[15:8];
  end

endmodule

`default_nettype wire

// ----- tb/dsbf_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the diagonal sharpen blend filter: predicts result beats and compares them.

module dsbf_checker
  import dsbf_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  input  wire logic         in_ready_i,
  input  wire pix_in_t      in_data_i,
  input  wire logic         out_valid_i,
  input  wire logic         out_ready_i,
  input  wire pix_out_t     out_data_i,
  input  wire logic         cfg_valid_i,
  input  wire logic         cfg_ready_i,
  input  wire logic [1:0]   cfg_index_i,
  input  wire logic [14:0]  cfg_data_i,
  output int unsigned       mismatch_count_o,
  output int unsigned       pending_o
);

  // Shadow copy of the line store, raster position and registers
  rgb_t        line_mem [2*MaxWidth];
  int unsigned col_pos;
  int unsigned row_pos;
  rgb_t        evict_a;
  rgb_t        evict_b;
  logic [10:0] reg_width;
  logic [14:0] reg_height;
  logic [6:0]  reg_strength;

  // Result beats still owed by the block, oldest first
  pix_out_t    expected_pixels [$];

  // Sharpen one channel, clamp, then blend with the original centre
  function automatic logic [7:0] blend_chan(logic [7:0] ul, logic [7:0] m, logic [7:0] lr,
                                            int unsigned s);
    int          v;
    int unsigned vc;
    int unsigned mm;
    mm = m;
    v  = 3 * int'(mm) - int'({24'd0, ul}) - int'({24'd0, lr});
    if (v < 0) vc = 0;
    else if (v > 255) vc = 255;
    else vc = v;
    return 8'((((vc * s * 256) / 100) + ((mm * (100 - s) * 256) / 100)) >> 8);
  endfunction

  function automatic rgb_t sharpen_pixel(rgb_t ul, rgb_t m, rgb_t lr, int unsigned s);
    return {blend_chan(ul[23:16], m[23:16], lr[23:16], s),
            blend_chan(ul[15:8],  m[15:8],  lr[15:8],  s),
            blend_chan(ul[7:0],   m[7:0],   lr[7:0],   s)};
  endfunction

  function automatic pix_out_t make_result(rgb_t px, int unsigned col, int unsigned row);
    pix_out_t o;
    o.red_out      = px[23:16];
    o.green_out    = px[15:8];
    o.blue_out     = px[7:0];
    o.out_col      = col[ColW-1:0];
    o.out_row      = row[RowW-1:0];
    o.last_of_item = 1'b0;
    return o;
  endfunction

  // Advance the shadow model by one input pixel and queue the beats it causes
  task automatic predict_results(pix_in_t p);
    int unsigned w, h, s, c, r, cur, prev;
    rgb_t        pix, evicted, centre, px;
    pix_out_t    res [3];
    int          n;
    n = 0;
    w = reg_width;
    h = reg_height;
    s = reg_strength;
    if (w == 0) w = 1;
    if (w > MaxWidth) w = MaxWidth;
    if (h == 0) h = 1;
    if (s > StrengthMax) s = StrengthMax;
    c = (col_pos > w - 1) ? w - 1 : col_pos;
    r = (row_pos > h - 1) ? h - 1 : row_pos;
    pix  = rgb_t'(p);
    cur  = (r & 1) * MaxWidth;
    prev = ((r & 1) ^ 1) * MaxWidth;
    evicted = line_mem[cur + c];
    line_mem[cur + c] = pix;
    if (r >= 1) begin
      if (c >= 1) begin
        centre = line_mem[prev + c - 1];
        px = (r >= 2 && c >= 2) ? sharpen_pixel(evict_b, centre, pix, s) : centre;
        res[n] = make_result(px, c - 1, r - 1);
        n++;
      end
      if (c == w - 1) begin
        res[n] = make_result(line_mem[prev + w - 1], w - 1, r - 1);
        n++;
      end
    end
    if (r == h - 1) begin
      res[n] = make_result(pix, c, r);
      n++;
    end
    if (n > 0) res[n-1].last_of_item = 1'b1;
    for (int i = 0; i < n; i++) expected_pixels.push_back(res[i]);
    evict_b = evict_a;
    evict_a = evicted;
    if (c >= w - 1) begin
      col_pos = 0;
      row_pos = (r >= h - 1) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endtask

  task automatic note_mismatch(string msg);
    mismatch_count_o++;
    if (mismatch_count_o <= 10) $display("%0t: MISMATCH %s", $time, msg);
  endtask

  // Compare one result beat against the oldest expectation
  task automatic check_result(pix_out_t got);
    pix_out_t want;
    if (expected_pixels.size() == 0) begin
      note_mismatch($sformatf("unexpected beat rgb=%02h%02h%02h col=%0d row=%0d last=%0b",
                              got.red_out, got.green_out, got.blue_out, got.out_col,
                              got.out_row, got.last_of_item));
      return;
    end
    want = expected_pixels.pop_front();
    if (got.red_out !== want.red_out || got.green_out !== want.green_out ||
        got.blue_out !== want.blue_out || got.out_col !== want.out_col ||
        got.out_row !== want.out_row || got.last_of_item !== want.last_of_item)
      note_mismatch({
        $sformatf("expected rgb=%02h%02h%02h col=%0d row=%0d last=%0b, ",
                  want.red_out, want.green_out, want.blue_out, want.out_col,
                  want.out_row, want.last_of_item),
        $sformatf("got rgb=%02h%02h%02h col=%0d row=%0d last=%0b",
                  got.red_out, got.green_out, got.blue_out, got.out_col,
                  got.out_row, got.last_of_item)});
  endtask

  // Watch all three channels at the rising edge; a pixel taken with a register
  // write still sees the old register value
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2 * MaxWidth; i++) line_mem[i] = '0;
      col_pos          = 0;
      row_pos          = 0;
      evict_a          = '0;
      evict_b          = '0;
      reg_width        = WidthReset;
      reg_height       = HeightReset;
      reg_strength     = StrengthReset;
      mismatch_count_o = 0;
      expected_pixels.delete();
      pending_o        = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_result(out_data_i);
      if (in_valid_i && in_ready_i) predict_results(in_data_i);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgImageWidth:  reg_width    = cfg_data_i[10:0];
          CfgImageHeight: reg_height   = cfg_data_i;
          CfgStrength:    reg_strength = cfg_data_i[6:0];
          default: ;
        endcase
      end
      pending_o = expected_pixels.size();
    end
  end

endmodule

// ----- tb/diagonal_sharpen_blend_filter_unit_tb.sv -----
`timescale 1ns / 100ps
// Top of the filter testbench: clock, reset, pixel and register stimulus, and verdict.

module diagonal_sharpen_blend_filter_unit_tb;
  import dsbf_pkg::*;

  // Index with no register behind it
  localparam logic [1:0] CfgNoReg = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  wire logic   in_ready;
  pix_in_t     in_data;
  wire logic   out_valid;
  logic        out_ready = 1'b0;
  pix_out_t    out_data;
  logic        cfg_valid;
  wire logic   cfg_ready;
  logic [1:0]  cfg_index;
  logic [14:0] cfg_data;
  int unsigned mismatches;
  int unsigned pending;

  int unsigned burst_left;
  int unsigned sent;

  diagonal_sharpen_blend_filter_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  dsbf_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_data_i       (out_data),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  // Receiver stall pattern: switch mode now and then, hold the mode in between
  int unsigned stall_tick = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_hold = 0;
  always @(negedge clk) begin
    stall_tick++;
    if (stall_tick % 97 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= 1'($urandom_range(0, 1));
      default: begin
        if (stall_hold == 0) begin
          out_ready <= ~out_ready;
          stall_hold = $urandom_range(1, 6);
        end else begin
          stall_hold--;
        end
      end
    endcase
  end

  // Offer one pixel beat in bursts with random gaps; return at the negedge after acceptance
  task automatic send_pixel(pix_in_t p);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_data  <= p;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  // Hold off until every owed result has come and the pipeline has emptied
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [14:0] val);
    wait_idle();
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random pixel, with channels pushed to the rails often enough to hit the clamps
  function automatic pix_in_t random_pixel();
    pix_in_t p;
    p = pix_in_t'(24'($urandom));
    if ($urandom_range(0, 3) == 0) begin
      p.red_in   = {8{p.red_in[0]}};
      p.green_in = {8{p.green_in[0]}};
      p.blue_in  = {8{p.blue_in[0]}};
    end
    return p;
  endfunction

  initial begin
    int unsigned w, h, s, n;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = CfgImageWidth;
    cfg_data   = '0;
    burst_left = 0;
    sent       = 0;
    rst_n      = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // 4x3 frame at full strength: clamp high at (1,1), clamp low at (1,2)
    write_reg(CfgImageWidth, 15'd4);
    write_reg(CfgImageHeight, 15'd3);
    write_reg(CfgStrength, 15'd100);
    send_pixel(24'h000000); send_pixel(24'hFFFFFF); send_pixel(24'h123456);
    send_pixel(24'hFF00FF);
    send_pixel(24'hA5A5A5); send_pixel(24'hFFFFFF); send_pixel(24'h000000);
    send_pixel(24'h5A5A5A);
    send_pixel(24'h0F0F0F); send_pixel(24'hF0F0F0); send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);

    // Oversized width and tallest height, then shrink both mid-frame
    write_reg(CfgStrength, 15'd0);
    write_reg(CfgImageWidth, 15'h7FFF);
    write_reg(CfgImageHeight, 15'h7FFF);
    send_pixel(24'h800000); send_pixel(24'h008001);
    write_reg(CfgImageWidth, 15'd1);
    write_reg(CfgImageHeight, 15'd1);
    send_pixel(24'h7F7F7F); send_pixel(24'h010203);

    // Zero sizes act as one
    write_reg(CfgImageWidth, 15'd0);
    write_reg(CfgImageHeight, 15'd0);
    send_pixel(24'hFEDCBA); send_pixel(24'h00FF00);

    // Strength above the limit, plus a write to the unused index
    write_reg(CfgStrength, 15'h7F7F);
    write_reg(CfgNoReg, 15'h7FFF);
    write_reg(CfgImageWidth, 15'd3);
    write_reg(CfgImageHeight, 15'd3);
    for (int i = 0; i < 9; i++) send_pixel(random_pixel());

    // Random phases: new sizes and strength, then whole frames or a broken one
    while (sent < 195) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
      h = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 6);
      case ($urandom_range(0, 5))
        0:       s = 0;
        1:       s = 100;
        2:       s = $urandom_range(101, 127);
        default: s = $urandom_range(0, 100);
      endcase
      write_reg(CfgImageWidth, {4'($urandom), 11'(w)});
      write_reg(CfgImageHeight, 15'(h));
      write_reg(CfgStrength, {8'($urandom), 7'(s)});
      if ($urandom_range(0, 7) == 0) write_reg(CfgNoReg, 15'($urandom));
      if (w == 0) w = 1;
      if (h == 0) h = 1;
      n = w * h * $urandom_range(1, 2);
      if ($urandom_range(0, 4) == 0) n = $urandom_range(1, w * h);
      if (n > 90) n = 90;
      for (int i = 0; i < n; i++) send_pixel(random_pixel());
    end

    // Drain and give the verdict
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- diagonal_sharpen_blend_filter_unit.f -----
hw/rtl/dsbf_pkg.sv
hw/rtl/dsbf_ram.sv
hw/rtl/dsbf_blend.sv
hw/rtl/diagonal_sharpen_blend_filter_unit.sv
tb/dsbf_checker.sv
tb/diagonal_sharpen_blend_filter_unit_tb.sv
